### hw/rtl/ast_pkg.sv
// Package for the array set table: command codes, field widths and the
// result record passed from the controller to the output stage.
// No dependencies.
package ast_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int FIELD_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [FIELD_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] count_after;
        logic               full_error;
    } t_result;

endpackage

### hw/rtl/ast_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ast_ctrl.sv
// Sequencer of the array set table: one read-and-compare unit on the entry
// RAM, used for the linear search and again for the shift on delete.
// Depends on ast_pkg and ast_ram.
module ast_ctrl #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ast_pkg::CMD_W-1:0]     i_cmd,
    input  logic [ast_pkg::VALUE_W-1:0]   i_value,
    input  logic [ast_pkg::FIELD_W-1:0]   i_cap,
    output logic                          o_idle,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ast_pkg::t_result              o_res
);
    import ast_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > FIELD_W) ? CW : FIELD_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_found, n_found;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_full, n_full;

    logic               scanning;
    logic               issue;
    logic               match;
    logic               at_cap;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;
    logic [CW-1:0]      shift_dst;

    // The scan issues one read per cycle while the index is below the count;
    // the compare sees the data in the next cycle.
    assign scanning  = (r_state == S_SEARCH) || (r_state == S_SHIFT);
    assign issue     = scanning && (r_idx < r_count);
    assign match     = r_rd_vld && (ram_rdata == r_value);
    assign at_cap    = (r_count >= CW'(MAX_ENTRIES)) || (EW'(r_count) >= EW'(i_cap));
    assign shift_dst = r_rd_idx - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_found   = r_found;
        n_pos     = r_pos;
        n_full    = r_full;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = r_value;

        if (scanning) begin
            n_rd_vld = issue;
            n_rd_idx = r_idx;
            if (issue) begin
                n_idx = r_idx + CW'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_cmd;
                    n_value  = i_value;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_full   = 1'b0;
                    n_state  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (match) begin
                    n_found = 1'b1;
                    n_pos   = r_rd_idx;
                    if (r_cmd == CMD_DELETE) begin
                        n_idx    = r_rd_idx + CW'(1);
                        n_rd_vld = 1'b0;
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (!r_rd_vld && !issue) begin
                    n_found = 1'b0;
                    n_pos   = r_count;
                    if (r_cmd == CMD_INSERT) begin
                        if (at_cap) begin
                            n_full = 1'b1;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (r_rd_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[AW-1:0];
                    ram_wdata = ram_rdata;
                end else if (!issue) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_full   <= n_full;
    end

    ast_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FINISH);

    always_comb begin
        o_res.found       = r_found;
        o_res.position    = FIELD_W'(r_pos);
        o_res.count_after = FIELD_W'(r_count);
        o_res.full_error  = r_full;
    end

endmodule

### hw/rtl/array_set_table_top.sv
// The block takes one command at a time: a new command is accepted only once
// the previous result has moved into the output register. The entry RAM is
// read one entry per cycle during the search and the shift on delete.
// Reset (synchronous, active low) empties the set and sets the capacity to 64.
module array_set_table_top #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: capacity limit, written whenever the enable is high.
    input  logic                                i_cfg_we,
    input  logic [ast_pkg::FIELD_W-1:0]         i_cfg_wdata,
    // Command channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ast_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [ast_pkg::VALUE_W-1:0]  i_value,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [ast_pkg::FIELD_W-1:0]         o_position,
    output logic [ast_pkg::FIELD_W-1:0]         o_count_after,
    output logic                                o_full_error
);
    import ast_pkg::*;

    logic [FIELD_W-1:0] r_cap;
    logic               r_out_valid;
    t_result            r_res;

    logic               ctrl_idle;
    logic               ctrl_res_valid;
    logic               ctrl_res_ready;
    t_result            ctrl_res;

    // The user must write the capacity register only while the block is idle (the
    // block does not enforce this), so the controller may read it at any point of an operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // A command transfer starts the sequencer; it stays busy until its result
    // has moved into the output register.
    assign o_in_ready = ctrl_idle;

    ast_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && ctrl_idle),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_cap       (r_cap),
        .o_idle      (ctrl_idle),
        .o_res_valid (ctrl_res_valid),
        .i_res_ready (ctrl_res_ready),
        .o_res       (ctrl_res)
    );

    // Output register: a finished result is loaded when the register is empty
    // or its current result is transferred in the same cycle.
    assign ctrl_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_res_ready) begin
            r_out_valid <= ctrl_res_valid;
        end
        if (ctrl_res_valid && ctrl_res_ready) begin
            r_res <= ctrl_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_res.found;
    assign o_position    = r_res.position;
    assign o_count_after = r_res.count_after;
    assign o_full_error  = r_res.full_error;

    // A command transfer always makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block still ready after command transfer");

    // A refused insert never comes with a found value.
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_error) |-> !o_found)
        else $error("full error reported for a present value");

    // A refused insert leaves the count alone and reports it as the position.
    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_error) |-> (o_position == o_count_after))
        else $error("full error with changed count");

endmodule

### tb/array_set_table_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for array_set_table_top: insert, delete and query traffic
// under changing capacity limits, checked against a behavioral table model.
// Depends on ast_pkg and array_set_table_top.
module array_set_table_top_test;
    import ast_pkg::*;

    // Table depth of the instance, and the size of the pool that random
    // values are mostly drawn from. The pool is larger than the table so that
    // a run of inserts can fill it and still find absent values to refuse.
    localparam int TABLE_DEPTH = 64;
    localparam int POOL_SIZE   = 80;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Error lines beyond this many are counted but not printed.
    localparam int PRINT_LIMIT = 40;

    // The fourth command code has no name in the package; the block treats
    // it as a query.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] arg;
    } t_set_cmd;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [FIELD_W-1:0]        cfg_wdata;
    logic                      in_valid;
    logic                      in_ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_ready;
    logic                      found;
    logic [FIELD_W-1:0]        position;
    logic [FIELD_W-1:0]        count_after;
    logic                      full_error;

    // Commands waiting to be driven, and the answers the table model has
    // worked out for commands that were accepted but not yet answered.
    t_set_cmd cmd_queue[$];
    t_result  set_answers[$];

    // Behavioral copy of the table: stored values, how many are held and the
    // capacity limit as last written.
    logic [VALUE_W-1:0] table_vals [0:TABLE_DEPTH-1];
    int unsigned        table_count;
    logic [FIELD_W-1:0] table_cap;

    logic [VALUE_W-1:0] value_pool [0:POOL_SIZE-1];

    t_set_cmd next_cmd;
    logic     cmd_taken;
    logic     quiet;
    int       in_gap;
    int       out_hold;
    int       cycles;
    int       mismatches;

    array_set_table_top #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_value      (value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_found      (found),
        .o_position   (position),
        .o_count_after(count_after),
        .o_full_error (full_error)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One line per mismatch, with the cycle it was seen on. Printing stops
    // after a while so a badly broken block does not flood the log, but every
    // mismatch is still counted.
    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s, got %0d, expected %0d", cycles, what, got, want);
        end
        mismatches++;
    endtask

    // Applies one command to the behavioral table and returns the answer the
    // block must give. The search only looks at held entries, so a slot that
    // was never written is never compared. The position of an absent value is
    // the count before the command; the effective capacity is the smaller of
    // the written limit and the table depth.
    task automatic run_set_command(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v,
                                   output t_result answer);
        int unsigned held;
        int unsigned hit;
        int unsigned room;
        int unsigned i;
        logic        present;
        logic        refused;
        held    = table_count;
        hit     = held;
        refused = 1'b0;
        for (i = 0; i < held; i++) begin
            if (hit == held && table_vals[i] == v) begin
                hit = i;
            end
        end
        present = (hit < held);
        room    = (table_cap < TABLE_DEPTH) ? table_cap : TABLE_DEPTH;
        if (op == CMD_INSERT) begin
            // A value already held is a no-op, even when the table is full.
            if (!present) begin
                if (held < room) begin
                    table_vals[held] = v;
                    table_count      = held + 1;
                end else begin
                    refused = 1'b1;
                end
            end
        end else if (op == CMD_DELETE) begin
            // Close the gap so the remaining entries keep their order.
            if (present) begin
                for (i = hit; i + 1 < held; i++) begin
                    table_vals[i] = table_vals[i + 1];
                end
                table_count = held - 1;
            end
        end
        answer.found       = present;
        answer.position    = hit[FIELD_W-1:0];
        answer.count_after = table_count[FIELD_W-1:0];
        answer.full_error  = refused;
    endtask

    // Rising edge: every handshake is judged here, on values that were driven
    // at the falling edge before, so the order of events in a step does not
    // matter. A command transfer runs the table model; a result transfer is
    // checked against the oldest answer still waiting.
    always @(posedge clk) begin : predict_and_check
        t_result predicted;
        t_result awaited;
        cmd_taken <= in_valid && in_ready;
        if (!rst_n) begin
            table_count = 0;
            table_cap   = CAP_RESET;
        end else begin
            if (cfg_we) begin
                table_cap = cfg_wdata;
            end
            if (in_valid && in_ready) begin
                run_set_command(cmd, value, predicted);
                set_answers.push_back(predicted);
            end
            if (out_valid && out_ready) begin
                if (set_answers.size() == 0) begin
                    flag_mismatch("result transfer with no command awaiting it", 1, 0);
                end else begin
                    awaited = set_answers.pop_front();
                    if (found !== awaited.found)
                        flag_mismatch("found", found, awaited.found);
                    if (position !== awaited.position)
                        flag_mismatch("position", position, awaited.position);
                    if (count_after !== awaited.count_after)
                        flag_mismatch("count_after", count_after, awaited.count_after);
                    if (full_error !== awaited.full_error)
                        flag_mismatch("full_error", full_error, awaited.full_error);
                end
            end
        end
    end

    // Command driver. A new command is presented only once the previous one
    // has been transferred (or nothing was presented), so valid and the
    // payload hold steady while the block is busy. After a command it may sit
    // out a random burst of idle cycles before the next one.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || cmd_taken)) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end else if (cmd_queue.size() != 0) begin
                next_cmd = cmd_queue.pop_front();
                in_valid <= 1'b1;
                cmd      <= next_cmd.op;
                value    <= next_cmd.arg;
                if (!quiet && $urandom_range(0, 4) == 0) begin
                    in_gap = $urandom_range(1, 13);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: ready drops for random bursts, independent
    // of whether a result is waiting.
    always @(negedge clk) begin
        if (out_hold > 0) begin
            out_ready <= 1'b0;
            out_hold = out_hold - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_ready <= 1'b0;
            out_hold = $urandom_range(1, 13) - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("array_set_table_top verification failed");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v);
        t_set_cmd c;
        c.op  = op;
        c.arg = v;
        cmd_queue.push_back(c);
    endtask

    // Waits until every queued command has been transferred and answered,
    // then lets the clock run on so the block is back at rest.
    task automatic wait_until_idle();
        do begin
            @(posedge clk);
        end while (cmd_queue.size() != 0 || in_valid || set_answers.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Capacity writes are single-cycle pulses and only happen while idle.
    task automatic write_capacity(input logic [FIELD_W-1:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random phase: write the capacity, then queue a mix of commands
    // weighted by the given insert and delete percentages. Most values come
    // from the shared pool so that hits, duplicates and deletes of held
    // values are common; the rest are fresh random words or extremes.
    task automatic run_phase(input logic [FIELD_W-1:0] cap, input int ins_pct,
                             input int del_pct, input int items);
        int                 n;
        int                 pick;
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] v;
        write_capacity(cap);
        for (n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct)
                op = CMD_INSERT;
            else if (pick < ins_pct + del_pct)
                op = CMD_DELETE;
            else if (pick < 97)
                op = CMD_QUERY;
            else
                op = CMD_SPARE;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick == 8)
                v = $urandom;
            else
                v = value_pool[$urandom_range(0, 3)];
            queue_cmd(op, v);
        end
        wait_until_idle();
    endtask

    initial begin : stimulus
        int k;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        cmd        = CMD_QUERY;
        value      = '0;
        out_ready  = 1'b0;
        cmd_taken  = 1'b0;
        quiet      = 1'b0;
        in_gap     = 0;
        out_hold   = 0;
        cycles     = 0;
        mismatches = 0;

        // The first pool slots hold the extremes of the value field.
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < POOL_SIZE; k++) begin
            value_pool[k] = $urandom;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity: extreme values, a duplicate
        // insert, queries of held and absent values, the spare command code,
        // a delete from the middle that shifts later entries, and a delete of
        // an absent value.
        queue_cmd(CMD_INSERT, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        queue_cmd(CMD_INSERT, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        queue_cmd(CMD_QUERY,  32'h0000_0000);
        queue_cmd(CMD_QUERY,  32'd12345);
        queue_cmd(CMD_SPARE,  32'hFFFF_FFFF);
        queue_cmd(CMD_DELETE, 32'h7FFF_FFFF);
        queue_cmd(CMD_DELETE, 32'd55);
        queue_cmd(CMD_QUERY,  32'hFFFF_FFFF);
        wait_until_idle();

        // Capacity equal to the count: an absent insert is refused, while
        // inserting a value already held is still a clean no-op.
        write_capacity(7'd3);
        queue_cmd(CMD_INSERT, 32'd5);
        queue_cmd(CMD_INSERT, 32'h0000_0000);
        wait_until_idle();

        // Capacity lowered below the count: entries stay, inserts are refused
        // until deletes bring the count under the limit. Deletes here hit the
        // first and the last entry.
        write_capacity(7'd1);
        queue_cmd(CMD_INSERT, 32'd7);
        queue_cmd(CMD_DELETE, 32'h8000_0000);
        queue_cmd(CMD_DELETE, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 32'd9);
        wait_until_idle();

        // Zero capacity refuses every absent insert; then operations on an
        // empty table.
        write_capacity(7'd0);
        queue_cmd(CMD_INSERT, 32'd9);
        queue_cmd(CMD_QUERY,  32'h0000_0000);
        queue_cmd(CMD_DELETE, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 32'd1);
        queue_cmd(CMD_DELETE, 32'd1);
        queue_cmd(CMD_QUERY,  32'd1);
        wait_until_idle();

        // Random part. The first phase is insert-heavy to fill the table to
        // its depth and hit the full condition; later phases move the limit
        // around, including above the depth, below the count and to zero.
        run_phase(7'd64,  70, 10, 106);
        run_phase(7'd127, 40, 40, 106);
        run_phase(7'd16,  45, 25, 106);
        run_phase(7'd1,   30, 50, 106);
        run_phase(7'($urandom_range(2, 63)), 50, 30, 106);
        run_phase(7'd0,   30, 40, 106);
        run_phase(7'd64,  60, 20, 106);

        // The last phase runs with no idling on either side, so any burst
        // still pending from before is dropped.
        quiet    = 1'b1;
        in_gap   = 0;
        out_hold = 0;
        run_phase(7'($urandom_range(1, 64)), 45, 35, 106);

        // Allow a worst-case command time for any stray late result.
        repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
        if (set_answers.size() != 0) begin
            flag_mismatch("answers never delivered", 0, set_answers.size());
        end
        if (mismatches == 0) begin
            $display("array_set_table_top verification clean");
        end else begin
            $display("array_set_table_top verification failed");
        end
        $finish;
    end

endmodule

### array_set_table_top.f
hw/rtl/ast_pkg.sv
hw/rtl/ast_ram.sv
hw/rtl/ast_ctrl.sv
hw/rtl/array_set_table_top.sv
tb/array_set_table_top_test.sv
